/* rtl/euler_view_matrix_builder_assert.svh */
// assertion macros used by the checker file
`ifndef EULER_VIEW_MATRIX_BUILDER_ASSERT_SVH
`define EULER_VIEW_MATRIX_BUILDER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define EVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define EVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/evmb_pkg.sv */
// package: payload types, cordic constants, arctangent table and rounding multiply
package evmb_pkg;

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} req_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic signed [31:0] col3;
		logic               last_row;
	} res_t;

	localparam int TABLE_LEN = 24;
	// q2.30 angle and gain constants; the angle constants are 35 bits signed to hold two pi
	localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q16     = 32'sd65536;

	// arctangent of 2^-i in q2.30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:  v = 34'sh3243F6A8;
			5'd1:  v = 34'sh1DAC6705;
			5'd2:  v = 34'sh0FADBAFC;
			5'd3:  v = 34'sh07F56EA6;
			5'd4:  v = 34'sh03FEAB76;
			5'd5:  v = 34'sh01FFD55B;
			5'd6:  v = 34'sh00FFFAAA;
			5'd7:  v = 34'sh007FFF55;
			5'd8:  v = 34'sh003FFFEA;
			5'd9:  v = 34'sh001FFFFD;
			5'd10: v = 34'sh000FFFFF;
			5'd11: v = 34'sh0007FFFF;
			5'd12: v = 34'sh0003FFFF;
			5'd13: v = 34'sh0001FFFF;
			5'd14: v = 34'sh0000FFFF;
			5'd15: v = 34'sh00007FFF;
			5'd16: v = 34'sh00003FFF;
			5'd17: v = 34'sh00001FFF;
			5'd18: v = 34'sh00000FFF;
			5'd19: v = 34'sh000007FF;
			5'd20: v = 34'sh000003FF;
			5'd21: v = 34'sh000001FF;
			5'd22: v = 34'sh000000FF;
			5'd23: v = 34'sh0000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

	// q2.30 product rounded half up
	function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		p = a * b + 68'sd536870912;
		return p[63:30];
	endfunction

endpackage

/* rtl/evmb_cordic.sv */
// pipelined sine and cosine unit: range reduction, one cordic step per stage, then a quadrant fix
module evmb_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [15:0] angle,
	output logic               out_valid,
	output logic signed [33:0] sin_q30,
	output logic signed [33:0] cos_q30
);

	localparam int N = (STEPS > evmb_pkg::TABLE_LEN) ? evmb_pkg::TABLE_LEN : STEPS;

	logic signed [34:0] z_wide;
	logic signed [34:0] z_wrap;
	logic signed [34:0] z_red;
	logic               flip_red;

	// range reduction into [-pi/2, pi/2]
	always_comb begin
		z_wide = 35'(angle) <<< 18;
		z_wrap = z_wide;
		if (z_wide > evmb_pkg::Q30_PI)
			z_wrap = z_wide - evmb_pkg::Q30_TWO_PI;
		else if (z_wide < -evmb_pkg::Q30_PI)
			z_wrap = z_wide + evmb_pkg::Q30_TWO_PI;
		z_red = z_wrap;
		flip_red = 1'b0;
		if (z_wrap > evmb_pkg::Q30_HALF_PI) begin
			z_red = z_wrap - evmb_pkg::Q30_PI;
			flip_red = 1'b1;
		end else if (z_wrap < -evmb_pkg::Q30_HALF_PI) begin
			z_red = z_wrap + evmb_pkg::Q30_PI;
			flip_red = 1'b1;
		end
	end

	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic signed [34:0] z_s [0:N];
	logic               f_s [0:N];
	logic               v_s [0:N];

	// reduced angle register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= in_valid;
	end
	always_ff @(posedge clk) begin
		x_s[0] <= evmb_pkg::CORDIC_GAIN;
		y_s[0] <= '0;
		z_s[0] <= z_red;
		f_s[0] <= flip_red;
	end

	// one rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else
				v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			f_s[i+1] <= f_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - 35'(evmb_pkg::atan_q30(5'(i)));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + 35'(evmb_pkg::atan_q30(5'(i)));
			end
		end
	end

	// quadrant fix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= v_s[N];
	end
	always_ff @(posedge clk) begin
		cos_q30 <= f_s[N] ? -x_s[N] : x_s[N];
		sin_q30 <= f_s[N] ? -y_s[N] : y_s[N];
	end

endmodule

/* rtl/euler_view_matrix_builder.sv */
// top level: euler angles and camera position to a 4x4 view matrix
//
// One request channel (start/busy) carries three q3.12 angles and a q16.16
// camera position. Each request yields four row results on the result
// channel, rows 0 to 3 in order, each marked by res_valid for one cycle;
// last_row flags row 3. The receiver cannot stall the results.
// A request is taken when start is high and busy is low. The cordic pipeline
// takes one request per cycle, but the shared result port emits one row per
// cycle, so busy is held after each accepted request while the spacing
// counter runs down, and the rows of two requests never overlap.
// Row 0 reaches the result ports through the cordic unit's CORDIC_STEPS + 2
// registers (CORDIC_STEPS capped at 24), the first loaded at the accepting
// edge, then two product stages, the row sequencer, the dot product stage
// and the output register; rows 1 to 3 follow back to back.
// Reset clears all valid bits and the request spacing counter; payload
// registers hold no reset.
module euler_view_matrix_builder #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  evmb_pkg::req_t    req,
	output logic              res_valid,
	output evmb_pkg::res_t    res
);

	localparam int N = (CORDIC_STEPS > evmb_pkg::TABLE_LEN) ? evmb_pkg::TABLE_LEN
		: CORDIC_STEPS;
	localparam int LAT = N + 1;

	logic       accept;
	logic [1:0] gap_q;

	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	// request spacing: busy holds after each accepted request until the counter reaches zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gap_q <= 2'd0;
		else if (accept)
			gap_q <= 2'd3;
		else if (gap_q != 2'd0)
			gap_q <= gap_q - 2'd1;
	end

	logic               vx, vy, vz;
	logic signed [33:0] sa, ca, sb, cb, sc, cc;

	evmb_cordic #(.STEPS(CORDIC_STEPS)) u_cx (.clk(clk), .arst_n(arst_n),
		.in_valid(accept), .angle(req.angle_x), .out_valid(vx), .sin_q30(sa),
		.cos_q30(ca));
	evmb_cordic #(.STEPS(CORDIC_STEPS)) u_cy (.clk(clk), .arst_n(arst_n),
		.in_valid(accept), .angle(req.angle_y), .out_valid(vy), .sin_q30(sb),
		.cos_q30(cb));
	evmb_cordic #(.STEPS(CORDIC_STEPS)) u_cz (.clk(clk), .arst_n(arst_n),
		.in_valid(accept), .angle(req.angle_z), .out_valid(vz), .sin_q30(sc),
		.cos_q30(cc));

	// position delay line alongside the cordic
	logic signed [31:0] px_d [0:LAT];
	logic signed [31:0] py_d [0:LAT];
	logic signed [31:0] pz_d [0:LAT];
	always_ff @(posedge clk) begin
		px_d[0] <= req.pos_x;
		py_d[0] <= req.pos_y;
		pz_d[0] <= req.pos_z;
		for (int k = 0; k < LAT; k++) begin
			px_d[k+1] <= px_d[k];
			py_d[k+1] <= py_d[k];
			pz_d[k+1] <= pz_d[k];
		end
	end

	// first products
	logic               v_s1;
	logic signed [33:0] sasb_s1, casb_s1;
	logic signed [33:0] cbcc_s1, cbsc_s1, sacb_s1, cacb_s1;
	logic signed [33:0] casc_s1, cacc_s1, sasc_s1, sacc_s1;
	logic signed [33:0] sb_s1, sc_s1, cc_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= vx & vy & vz;
	end
	always_ff @(posedge clk) begin
		sasb_s1 <= evmb_pkg::mul30(sa, sb);
		casb_s1 <= evmb_pkg::mul30(ca, sb);
		cbcc_s1 <= evmb_pkg::mul30(cb, cc);
		cbsc_s1 <= evmb_pkg::mul30(cb, sc);
		sacb_s1 <= evmb_pkg::mul30(sa, cb);
		cacb_s1 <= evmb_pkg::mul30(ca, cb);
		casc_s1 <= evmb_pkg::mul30(ca, sc);
		cacc_s1 <= evmb_pkg::mul30(ca, cc);
		sasc_s1 <= evmb_pkg::mul30(sa, sc);
		sacc_s1 <= evmb_pkg::mul30(sa, cc);
		sb_s1   <= sb;
		sc_s1   <= sc;
		cc_s1   <= cc;
		px_s1   <= px_d[LAT];
		py_s1   <= py_d[LAT];
		pz_s1   <= pz_d[LAT];
	end

	// second products, full rotation matrix rounded to q16.16
	function automatic logic signed [31:0] to_q16(input logic signed [34:0] v);
		logic signed [34:0] t;
		t = v + 35'sd8192;
		return 32'(t >>> 14);
	endfunction

	logic               v_s2;
	logic signed [31:0] r_s2 [0:8];
	logic signed [31:0] px_s2, py_s2, pz_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		r_s2[0] <= to_q16(35'(cbcc_s1));
		r_s2[1] <= to_q16(35'(cbsc_s1));
		r_s2[2] <= to_q16(35'(sb_s1));
		r_s2[3] <= to_q16(-35'(casc_s1) - 35'(evmb_pkg::mul30(sasb_s1, cc_s1)));
		r_s2[4] <= to_q16(35'(cacc_s1) - 35'(evmb_pkg::mul30(sasb_s1, sc_s1)));
		r_s2[5] <= to_q16(35'(sacb_s1));
		r_s2[6] <= to_q16(35'(sasc_s1) - 35'(evmb_pkg::mul30(casb_s1, cc_s1)));
		r_s2[7] <= to_q16(-35'(sacc_s1) - 35'(evmb_pkg::mul30(casb_s1, sc_s1)));
		r_s2[8] <= to_q16(35'(cacb_s1));
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		pz_s2 <= pz_s1;
	end

	// row sequencer: hold the matrix and step through rows
	logic               row_act_q;
	logic [1:0]         row_q;
	logic signed [31:0] m_q [0:8];
	logic signed [31:0] px_q, py_q, pz_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_act_q <= 1'b0;
			row_q     <= 2'd0;
		end else if (v_s2) begin
			row_act_q <= 1'b1;
			row_q     <= 2'd0;
		end else if (row_act_q) begin
			row_q     <= row_q + 2'd1;
			row_act_q <= (row_q != 2'd3);
		end
	end
	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int k = 0; k < 9; k++)
				m_q[k] <= r_s2[k];
			px_q <= px_s2;
			py_q <= py_s2;
			pz_q <= pz_s2;
		end
	end

	// row select and products with the position
	logic               v_s3;
	logic [1:0]         row_s3;
	logic signed [31:0] e0_s3, e1_s3, e2_s3;
	logic signed [63:0] p0_s3, p1_s3, p2_s3;
	logic signed [31:0] e0, e1, e2;
	always_comb begin
		case (row_q)
			2'd0: begin e0 = m_q[0]; e1 = m_q[1]; e2 = m_q[2]; end
			2'd1: begin e0 = m_q[3]; e1 = m_q[4]; e2 = m_q[5]; end
			2'd2: begin e0 = m_q[6]; e1 = m_q[7]; e2 = m_q[8]; end
			default: begin e0 = '0; e1 = '0; e2 = '0; end
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= row_act_q;
	end
	always_ff @(posedge clk) begin
		row_s3 <= row_q;
		e0_s3  <= e0;
		e1_s3  <= e1;
		e2_s3  <= e2;
		p0_s3  <= e0 * px_q;
		p1_s3  <= e1 * py_q;
		p2_s3  <= e2 * pz_q;
	end

	// sum, round, negate and saturate
	logic signed [65:0] acc;
	logic signed [65:0] tr;
	logic signed [31:0] t_sat;
	always_comb begin
		acc = 66'(p0_s3) + 66'(p1_s3) + 66'(p2_s3) + 66'sd32768;
		tr  = -(acc >>> 16);
		if (tr > 66'sd2147483647)
			t_sat = 32'sh7FFFFFFF;
		else if (tr < -66'sd2147483648)
			t_sat = 32'sh80000000;
		else
			t_sat = tr[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else
			res_valid <= v_s3;
	end
	always_ff @(posedge clk) begin
		res.row_index <= row_s3;
		res.last_row  <= (row_s3 == 2'd3);
		if (row_s3 == 2'd3) begin
			res.col0 <= '0;
			res.col1 <= '0;
			res.col2 <= '0;
			res.col3 <= evmb_pkg::ONE_Q16;
		end else begin
			res.col0 <= e0_s3;
			res.col1 <= e1_s3;
			res.col2 <= e2_s3;
			res.col3 <= t_sat;
		end
	end

endmodule

/* rtl/evmb_checker.sv */
// port checker for the view matrix builder, bound to the top level
`include "euler_view_matrix_builder_assert.svh"
module evmb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           res_valid,
	input evmb_pkg::res_t res
);

	`EVM_ASSERT_IMP(a_last_flag, clk, arst_n, res_valid, res.last_row == (res.row_index == 2'd3))
	`EVM_ASSERT_NXT(a_row_order, clk, arst_n, res_valid && res.row_index != 2'd3, res_valid && res.row_index == $past(res.row_index) + 2'd1)
	`EVM_ASSERT_NXT(a_busy_after, clk, arst_n, start && !busy, busy)
	`EVM_ASSERT_IMP(a_last_row_val, clk, arst_n, res_valid && res.last_row, res.col3 == 32'sd65536 && res.col0 == 32'sd0)

endmodule

bind euler_view_matrix_builder evmb_checker u_evmb_checker (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .res_valid(res_valid), .res(res));
